FILE: sv/sm3_pkg.sv
// ============================================================================
// sm3_pkg
// Shared types, constants and bit functions for the SM3 stream hasher.
// ============================================================================
package sm3_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  // Control from the sequencer to the message window.
  typedef struct packed {
    logic       push;   // shift one message byte in
    logic [7:0] data;
    logic       step;   // one expansion step (one round)
  } sched_ctl_t;

  localparam word_t IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] PHASE_POS  = 6'd16;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  function automatic word_t rotl32(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

endpackage

FILE: sv/sm3_hash_stream.sv
// ============================================================================
// sm3_hash_stream
// SM3 hash over a byte stream; emits the 256-bit digest as eight words.
// ============================================================================
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tdata[7:0] message byte, tuser byte valid, tlast end
//  m_axis   | out | tdata[31:0] digest word (word 0 first), tlast on word 7
//
//  A byte beat that fills the 64-byte block starts a compression: its
//  64 rounds run one at a time through the single shared round unit.
//  A tlast beat adds padding bytes at one per cycle up to the block end
//  (one extra block when fewer than 9 bytes were free), one compression
//  per padded block, then eight output beats, each held until taken.
//  Synchronous reset returns the chaining value to the initial value and
//  empties the block; tready stays low outside the idle state.
//
module sm3_hash_stream (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // is_last

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // word_last
);
  import sm3_pkg::*;

  state_t      state, state_next;
  state_t      ret, ret_next;        // where to go after a compression
  logic [5:0]  fill, fill_next;      // bytes held in the current block
  logic [60:0] byte_count, byte_count_next;
  logic        pad_first, pad_first_next;  // next pad byte is the 0x80 marker
  logic        len_ok, len_ok_next;        // this block carries the length
  logic [2:0]  wcnt, wcnt_next;

  logic        s_acc, m_acc;
  logic        push, start, iv_load;
  logic [7:0]  push_byte, pad_byte;
  logic [63:0] bit_len;

  sched_ctl_t  sched_ctl;
  word_t       w, wp;
  word_t       cv [8];
  logic        busy, done;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_acc   = m_axis_tvalid && m_axis_tready;
  assign bit_len = {byte_count, 3'b000};

  // Length bytes go out big-endian at block positions 56..63.
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (len_ok && fill >= LEN_POS) begin
      pad_byte = bit_len[8*(7 - 32'(fill[2:0])) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // ---- output / control decode ----
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    push      = 1'b0;
    push_byte = s_axis_tdata;
    iv_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        push = s_acc && s_axis_tuser;
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
      end
      ST_OUT: begin
        iv_load = m_acc && (wcnt == LAST_WORD);
      end
      default: begin
      end
    endcase
    start = push && (fill == LAST_POS);
  end

  assign m_axis_tdata = cv[wcnt];
  assign m_axis_tlast = (wcnt == LAST_WORD);

  assign sched_ctl.push = push;
  assign sched_ctl.data = push_byte;
  assign sched_ctl.step = busy;

  // ---- next state ----
  always_comb begin
    state_next      = state;
    ret_next        = ret;
    fill_next       = fill;
    byte_count_next = byte_count;
    pad_first_next  = pad_first;
    len_ok_next     = len_ok;
    wcnt_next       = wcnt;
    if (push) begin
      fill_next = fill + 6'd1;
    end
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser) begin
            byte_count_next = byte_count + 61'd1;
          end
          pad_first_next = s_axis_tlast;
          if (start) begin
            state_next = ST_COMP;
            ret_next   = s_axis_tlast ? ST_PAD : ST_IDLE;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_first_next = 1'b0;
        if (pad_first) begin
          len_ok_next = (fill < LEN_POS);
        end
        if (start) begin
          state_next = ST_COMP;
          // marker in the last 8 slots: one more block for the length
          ret_next = (len_ok && !pad_first) ? ST_OUT : ST_PAD;
        end
      end
      ST_COMP: begin
        if (done) begin
          state_next = ret;
          if (ret == ST_PAD) begin
            len_ok_next = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (m_acc) begin
          wcnt_next = wcnt + 3'd1;
          if (wcnt == LAST_WORD) begin
            state_next      = ST_IDLE;
            byte_count_next = '0;
            len_ok_next     = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret        <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      pad_first  <= 1'b0;
      len_ok     <= 1'b0;
      wcnt       <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      fill       <= fill_next;
      byte_count <= byte_count_next;
      pad_first  <= pad_first_next;
      len_ok     <= len_ok_next;
      wcnt       <= wcnt_next;
    end
  end

  sm3_msg_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w),
    .wp  (wp)
  );

  sm3_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .iv_load (iv_load),
    .w       (w),
    .wp      (wp),
    .busy    (busy),
    .done    (done),
    .cv      (cv)
  );

endmodule

FILE: sv/sm3_msg_sched.sv
// ============================================================================
// sm3_msg_sched
// 16-word message window: loads bytes, then expands one word per round.
// ============================================================================
module sm3_msg_sched (
  input  logic                clk,
  input  sm3_pkg::sched_ctl_t ctl,
  output sm3_pkg::word_t      w,    // W[j]
  output sm3_pkg::word_t      wp    // W[j] ^ W[j+4]
);
  import sm3_pkg::*;

  // blk[511 -: 32] is W[j], next word below it
  logic [511:0] blk;
  word_t        wn;

  function automatic word_t wsel(input logic [511:0] b, input int i);
    return b[511 - 32*i -: 32];
  endfunction

  assign w  = wsel(blk, 0);
  assign wp = wsel(blk, 0) ^ wsel(blk, 4);

  assign wn = perm1(wsel(blk, 0) ^ wsel(blk, 7) ^ rotl32(wsel(blk, 13), 5'd15))
            ^ rotl32(wsel(blk, 3), 5'd7) ^ wsel(blk, 10);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      blk <= {blk[503:0], ctl.data};
    end else if (ctl.step) begin
      blk <= {blk[479:0], wn};
    end
  end

endmodule

FILE: sv/sm3_round.sv
// ============================================================================
// sm3_round
// One SM3 compression round on the working variables A..H.
// ============================================================================
module sm3_round (
  input  sm3_pkg::word_t v     [8],
  input  logic [5:0]     j,
  input  sm3_pkg::word_t w,
  input  sm3_pkg::word_t wp,
  output sm3_pkg::word_t v_next [8]
);
  import sm3_pkg::*;

  word_t tj, a12, ss1, ss2, f, g, tt1, tt2;
  logic  early;

  assign early = (j < PHASE_POS);
  assign tj    = rotl32(early ? T_LOW : T_HIGH, j[4:0]);
  assign a12   = rotl32(v[0], 5'd12);
  assign ss1   = rotl32(a12 + v[4] + tj, 5'd7);
  assign ss2   = ss1 ^ a12;

  always_comb begin
    if (early) begin
      f = v[0] ^ v[1] ^ v[2];
      g = v[4] ^ v[5] ^ v[6];
    end else begin
      f = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      g = (v[4] & v[5]) | (~v[4] & v[6]);
    end
  end

  assign tt1 = f + v[3] + ss2 + wp;
  assign tt2 = g + v[7] + ss1 + w;

  assign v_next[0] = tt1;
  assign v_next[1] = v[0];
  assign v_next[2] = rotl32(v[1], 5'd9);
  assign v_next[3] = v[2];
  assign v_next[4] = perm0(tt2);
  assign v_next[5] = v[4];
  assign v_next[6] = rotl32(v[5], 5'd19);
  assign v_next[7] = v[6];

endmodule

FILE: sv/sm3_compress.sv
// ============================================================================
// sm3_compress
// Round sequencer: 64 passes through one shared round, then folds into CV.
// ============================================================================
module sm3_compress (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,    // block complete at this edge
  input  logic           iv_load,  // return CV to the initial value
  input  sm3_pkg::word_t w,
  input  sm3_pkg::word_t wp,
  output logic           busy,
  output logic           done,     // last round this cycle
  output sm3_pkg::word_t cv [8]
);
  import sm3_pkg::*;

  word_t      v      [8];
  word_t      v_next [8];
  logic [5:0] rnd;

  sm3_round u_round (
    .v      (v),
    .j      (rnd),
    .w      (w),
    .wp     (wp),
    .v_next (v_next)
  );

  assign done = busy && (rnd == LAST_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      rnd <= rnd + 6'd1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= cv;
    end else if (busy) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || iv_load) begin
      cv <= IV;
    end else if (done) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= cv[i] ^ v_next[i];
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// ============================================================================
// testbench
// Self-checking stream test for sm3_hash_stream: message bytes go in on
// s_axis, digest words are predicted from a behavioral SM3 model kept here
// and compared with every m_axis beat. Both sides idle and stall at random.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 210;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned MAX_SHOWN   = 10;

  // SM3 constants for the predictor
  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] ROUND_T_EARLY = 32'h79CC4519;
  localparam logic [31:0] ROUND_T_LATE  = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam int unsigned LEN_FIELD_POS = 56;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0;    // [0] byte_valid
  logic        s_axis_tlast  = 1'b0;    // is_last

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [31:0] digest_word
  logic        m_axis_tlast;            // word_last

  sm3_hash_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // SM3 predictor state
  // --------------------------------------------------------------------------
  logic [31:0]  chain_val [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [60:0]  msg_len;     // wraps like the hardware byte counter

  digest_beat_t digest_q [$];

  // run statistics
  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  bytes_sent;
  int unsigned  ignored_sent;
  int unsigned  messages_sent;
  int unsigned  longest_msg;
  int unsigned  cur_msg;
  int unsigned  words_checked;
  int unsigned  cycle_count;

  // idle shaping: steady mode switches the random gaps off
  logic         tx_steady;
  logic         rx_steady;

  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned n);
    int unsigned r;
    r = n % 32;
    if (r == 0) return x;
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_p0(logic [31:0] x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic logic [31:0] mix_p1(logic [31:0] x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  function automatic void clear_hash_state();
    for (int k = 0; k < 8; k++) chain_val[k] = SM3_IV[k];
    fill    = 0;
    msg_len = '0;
  endfunction

  function automatic void compress_buffer();
    logic [31:0] w [68];
    logic [31:0] wx [64];
    logic [31:0] v [8];
    logic [31:0] a12, ss1, ss2, tt1, tt2, ff, gg, tj;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15)) ^
             rot_left(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 64; j++) wx[j] = w[j] ^ w[j+4];
    for (int k = 0; k < 8; k++) v[k] = chain_val[k];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? ROUND_T_EARLY : ROUND_T_LATE;
      a12 = rot_left(v[0], 12);
      ss1 = rot_left(a12 + v[4] + rot_left(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1  = ff + v[3] + ss2 + wx[j];
      tt2  = gg + v[7] + ss1 + w[j];
      v[3] = v[2];
      v[2] = rot_left(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rot_left(v[5], 19);
      v[5] = v[4];
      v[4] = mix_p0(tt2);
    end
    for (int k = 0; k < 8; k++) chain_val[k] ^= v[k];
  endfunction

  // Fold one accepted beat into the model; a closing beat queues the digest.
  function automatic void absorb_beat(logic [7:0] data, logic valid, logic last);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (valid) begin
      blk[fill] = data;
      fill      = fill + 1;
      msg_len   = msg_len + 61'd1;
      if (fill == 64) begin
        compress_buffer();
        fill = 0;
      end
    end
    if (!last) return;
    blk[fill] = PAD_MARK;
    fill      = fill + 1;
    // no room left for the length field: zero out and spend one more block
    if (fill > LEN_FIELD_POS) begin
      while (fill < 64) begin
        blk[fill] = 8'h00;
        fill      = fill + 1;
      end
      compress_buffer();
      fill = 0;
    end
    while (fill < LEN_FIELD_POS) begin
      blk[fill] = 8'h00;
      fill      = fill + 1;
    end
    bit_len = {msg_len, 3'b000};
    for (int k = 0; k < 8; k++) blk[LEN_FIELD_POS + k] = bit_len[63 - 8*k -: 8];
    compress_buffer();
    for (int k = 0; k < 8; k++) begin
      beat.word = chain_val[k];
      beat.last = (k == 7);
      digest_q.push_back(beat);
    end
    clear_hash_state();
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one beat per call. tvalid stays high between back-to-back beats.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] data, input logic valid, input logic last);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb_beat(data, valid, last);
    if (valid) begin
      bytes_sent = bytes_sent + 1;
      cur_msg    = cur_msg + 1;
    end
    if (valid || last) items_sent = items_sent + 1;
    else ignored_sent = ignored_sent + 1;
    if (last) begin
      messages_sent = messages_sent + 1;
      if (cur_msg > longest_msg) longest_msg = cur_msg;
      cur_msg = 0;
    end
  endtask

  // Holds the sender off until every queued digest word has come out.
  task automatic wait_for_digests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall before each result beat, sometimes none for a while
  // --------------------------------------------------------------------------
  initial begin : digest_sink
    int unsigned stall;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Result check against the oldest expected digest word.
  always @(posedge clk) begin : digest_check
    digest_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected digest beat: word=%08h last=%0b", m_axis_tdata, m_axis_tlast);
      end else begin
        want          = digest_q.pop_front();
        words_checked = words_checked + 1;
        if (m_axis_tdata !== want.word || m_axis_tlast !== want.last) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_SHOWN)
            $display("digest mismatch: word exp=%08h got=%08h, last exp=%0b got=%0b",
                     want.word, m_axis_tdata, want.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words pending",
               cycle_count, digest_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Last beat without a byte on a fresh hasher: digest of the empty string.
  task automatic test_empty_message();
    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // "abc", the closing byte carrying tlast on the same beat.
  task automatic test_byte_with_last();
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
  endtask

  // Extreme byte values, then a separate closing beat with no byte.
  task automatic test_separate_last();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // Beats with neither byte nor last must leave the message untouched.
  task automatic test_ignored_beats();
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);
  endtask

  // Random messages; lengths lean toward the padding boundaries around
  // 55/56 and 64 bytes, with a few spanning two or more blocks.
  task automatic test_random_messages();
    int unsigned len, pick, start;
    logic        own_last;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(0, 12);
      else if (pick < 92) len = $urandom_range(52, 66);
      else                len = $urandom_range(100, 140);
      own_last  = (len > 0) && ($urandom_range(0, 1) == 1);
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1, own_last && (i == len - 1));
      end
      if (!own_last) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    tx_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    fail_count    = 0;
    items_sent    = 0;
    bytes_sent    = 0;
    ignored_sent  = 0;
    messages_sent = 0;
    longest_msg   = 0;
    cur_msg       = 0;
    words_checked = 0;
    cycle_count   = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    clear_hash_state();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_byte_with_last();
    test_separate_last();
    test_ignored_beats();
    wait_for_digests();
    test_random_messages();

    // drain, then give the block time for anything it should not emit
    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d messages (%0d bytes, longest %0d, %0d ignored beats)",
             messages_sent, bytes_sent, longest_msg, ignored_sent);
    $display("checked %0d digest words, %0d failures", words_checked, fail_count);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sm3_pkg.sv
sv/sm3_msg_sched.sv
sv/sm3_round.sv
sv/sm3_compress.sv
sv/sm3_hash_stream.sv
verif/testbench.sv
